>>> hdl/mexp_pkg.sv
// ============================================================================
// mexp_pkg: shared types and constants for the modular exponentiation block
// Field widths, the fixed prime, Barrett constants and the command/status
// structs that join the controller and the datapath.
// ============================================================================
`default_nettype none

package mexp_pkg;

	// Field widths
	localparam int unsigned ValueWidth  = 63;
	localparam int unsigned ResWidth    = 30;
	localparam int unsigned RedCntWidth = 5;

	// Fixed prime and Barrett reciprocal floor(2^60 / prime)
	localparam logic [ResWidth-1:0] PrimeMod  = 30'd1000000007;
	localparam logic [30:0]         BarrettMu = 31'((64'd1 << 60) / 64'd1000000007);

	// Exponent used for the modular inverse (prime minus two)
	localparam logic [ValueWidth-1:0] InvExp = 63'(PrimeMod) - 63'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture a new request
		logic red_step;  // reduce two more base bits
		logic issue;     // start square and multiply
		logic update;    // take the products, shift the exponent
		logic emit;      // copy the accumulator to the output register
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic red_last;  // final base reduction step
		logic exp_zero;  // no set exponent bits remain
		logic mul_done;  // both products are ready
	} dp_status_t;

endpackage

`default_nettype wire

>>> hdl/mexp_mulmod.sv
// ============================================================================
// mexp_mulmod: pipelined modular multiplier
// Four-stage Barrett multiply modulo the fixed prime: product, quotient
// estimate, quotient times prime, then subtract and final correction.
// ============================================================================
`default_nettype none

module mexp_mulmod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           issue,
	input  logic [mexp_pkg::ResWidth-1:0]  a,
	input  logic [mexp_pkg::ResWidth-1:0]  b,
	output logic                           done,
	output logic [mexp_pkg::ResWidth-1:0]  product
);
	import mexp_pkg::*;

	localparam logic [32:0] Mod1 = 33'(PrimeMod);
	localparam logic [32:0] Mod2 = 33'(PrimeMod) * 33'd2;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [59:0] p_s1;
	logic [30:0] q3_s2;
	logic [31:0] x_s2, x_s3;
	logic [31:0] qp_s3;
	logic [ResWidth-1:0] r_s4;

	logic [61:0] q2_full;
	logic [60:0] qp_full;
	logic [31:0] rem;
	logic [32:0] rem_m1, rem_m2;
	logic [ResWidth-1:0] rem_fix;

	// Track which stages hold live work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Quotient estimate and its multiple of the prime
	always_comb begin
		q2_full = 62'(p_s1[59:29]) * 62'(BarrettMu);
		qp_full = 61'(q3_s2) * 61'(PrimeMod);
	end

	// Remainder is below three primes: subtract the prime once or twice
	always_comb begin
		rem    = x_s3 - qp_s3;
		rem_m1 = {1'b0, rem} - Mod1;
		rem_m2 = {1'b0, rem} - Mod2;
		priority if (!rem_m2[32]) begin
			rem_fix = rem_m2[ResWidth-1:0];
		end else if (!rem_m1[32]) begin
			rem_fix = rem_m1[ResWidth-1:0];
		end else begin
			rem_fix = rem[ResWidth-1:0];
		end
	end

	// Advance the arithmetic pipeline
	always_ff @(posedge clk) begin
		p_s1  <= 60'(a) * 60'(b);
		q3_s2 <= q2_full[61:31];
		x_s2  <= p_s1[31:0];
		qp_s3 <= qp_full[31:0];
		x_s3  <= x_s2;
		r_s4  <= rem_fix;
	end

	assign done    = v_s4;
	assign product = r_s4;

endmodule

`default_nettype wire

>>> hdl/mexp_dp.sv
// ============================================================================
// mexp_dp: modular exponentiation datapath
// Holds base, exponent, square and accumulator; reduces the base two bits a
// cycle and runs the square and the conditional multiply on two multipliers.
// ============================================================================
`default_nettype none

module mexp_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mexp_pkg::ctrl_cmd_t              cmd,
	output mexp_pkg::dp_status_t             status,
	input  logic [mexp_pkg::ValueWidth-1:0]  base_value,
	input  logic [mexp_pkg::ValueWidth-1:0]  exponent_value,
	input  logic                             inverse_mode,
	output logic [mexp_pkg::ResWidth-1:0]    power_result
);
	import mexp_pkg::*;

	localparam logic [32:0] Mod1 = 33'(PrimeMod);
	localparam logic [32:0] Mod2 = 33'(PrimeMod) * 33'd2;
	localparam logic [32:0] Mod3 = 33'(PrimeMod) * 33'd3;

	logic [ValueWidth:0]   base_q;
	logic [ValueWidth-1:0] e_q;
	logic [ResWidth-1:0]   sq_q, acc_q, res_q;
	logic [RedCntWidth-1:0] cnt_q;

	logic [31:0] red_val;
	logic [32:0] red_m1, red_m2, red_m3;
	logic [ResWidth-1:0] red_next;
	logic [ResWidth-1:0] sq_prod, acc_prod;
	logic sq_done, acc_done;

	// Shift in two base bits and subtract up to three primes
	always_comb begin
		red_val = {sq_q, base_q[ValueWidth:ValueWidth-1]};
		red_m1  = {1'b0, red_val} - Mod1;
		red_m2  = {1'b0, red_val} - Mod2;
		red_m3  = {1'b0, red_val} - Mod3;
		priority if (!red_m3[32]) begin
			red_next = red_m3[ResWidth-1:0];
		end else if (!red_m2[32]) begin
			red_next = red_m2[ResWidth-1:0];
		end else if (!red_m1[32]) begin
			red_next = red_m1[ResWidth-1:0];
		end else begin
			red_next = red_val[ResWidth-1:0];
		end
	end

	// Count reduction steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.red_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Hold the operands and the running results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= {1'b0, base_value};
			e_q    <= inverse_mode ? InvExp : exponent_value;
			sq_q   <= '0;
			acc_q  <= ResWidth'(1);
		end else if (cmd.red_step) begin
			base_q <= base_q << 2;
			sq_q   <= red_next;
		end else if (cmd.update) begin
			sq_q <= sq_prod;
			if (e_q[0]) begin
				acc_q <= acc_prod;
			end
			e_q <= e_q >> 1;
		end
		if (cmd.emit) begin
			res_q <= acc_q;
		end
	end

	// Square the power
	mexp_mulmod u_sq_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (cmd.issue),
		.a       (sq_q),
		.b       (sq_q),
		.done    (sq_done),
		.product (sq_prod)
	);

	// Multiply the accumulator by the power
	mexp_mulmod u_acc_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (cmd.issue),
		.a       (acc_q),
		.b       (sq_q),
		.done    (acc_done),
		.product (acc_prod)
	);

	always_comb begin
		status.red_last = &cnt_q;
		status.exp_zero = (e_q == '0);
		status.mul_done = sq_done & acc_done;
	end

	assign power_result = res_q;

endmodule

`default_nettype wire

>>> hdl/mexp_ctrl.sv
// ============================================================================
// mexp_ctrl: modular exponentiation controller
// Sequences base reduction, one square-and-multiply per exponent bit and the
// hand-off to the output register.
// ============================================================================
`default_nettype none

module mexp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output mexp_pkg::ctrl_cmd_t   cmd,
	input  mexp_pkg::dp_status_t  status
);
	import mexp_pkg::*;

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StReduce = 3'd1;
	localparam logic [2:0] StCheck  = 3'd2;
	localparam logic [2:0] StWait   = 3'd3;
	localparam logic [2:0] StDone   = 3'd4;

	logic [2:0] state_q, state_next;
	logic       out_valid_q;

	// Next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			StIdle: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = StReduce;
				end
			end
			StReduce: begin
				cmd.red_step = 1'b1;
				if (status.red_last) begin
					state_next = StCheck;
				end
			end
			StCheck: begin
				if (status.exp_zero) begin
					state_next = StDone;
				end else begin
					cmd.issue  = 1'b1;
					state_next = StWait;
				end
			end
			StWait: begin
				if (status.mul_done) begin
					cmd.update = 1'b1;
					state_next = StCheck;
				end
			end
			StDone: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit   = 1'b1;
					state_next = StIdle;
				end
			end
			default: begin
				state_next = StIdle;
			end
		endcase
	end

	// Advance the state, hold the output valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != StIdle);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/modular_exponentiation.sv
// Modular exponentiation: power_result = base_value ^ exponent_value mod
// 1000000007, or the modular inverse of base_value when inverse_mode is set
// (exponent 1000000005). One request is worked on at a time. After a request
// is taken, the base is reduced two bits a cycle, then each exponent bit up to
// the highest set one runs through a check state and the four-stage pipelined
// Barrett multipliers (square and multiply run side by side). The result sits
// in an output register, so a new request is taken as soon as the result is
// written there.
// ============================================================================
// modular_exponentiation: top level
// Joins the controller and the datapath.
// ============================================================================
`default_nettype none

module modular_exponentiation (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [mexp_pkg::ValueWidth-1:0]  base_value,
	input  logic [mexp_pkg::ValueWidth-1:0]  exponent_value,
	input  logic                             inverse_mode,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mexp_pkg::ResWidth-1:0]    power_result
);
	import mexp_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequence the work
	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Do the arithmetic
	mexp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.inverse_mode   (inverse_mode),
		.power_result   (power_result)
	);

endmodule

`default_nettype wire

>>> hdl/mexp_chk.sv
// ============================================================================
// mexp_chk: port checker for modular_exponentiation
// Watches the top-level ports for result holding, range and busy behavior.
// ============================================================================
`default_nettype none

module mexp_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [mexp_pkg::ResWidth-1:0]    power_result
);
	import mexp_pkg::*;

	logic in_take;
	assign in_take = in_valid && !in_stall;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(power_result))
		else $error("stalled result changed");

	// Keep results below the prime
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> power_result < PrimeMod)
		else $error("result not reduced");

	// Go busy after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("request taken while not going busy");

	// Never produce a result in the cycle after a request
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (.*);

`default_nettype wire
